>>> rtl/source_text_tokenizer_unit_assert.svh
// Assertion macros shared by the tokenizer RTL.
// Define NO_ASSERTIONS to compile every check away.
`ifndef SOURCE_TEXT_TOKENIZER_UNIT_ASSERT_SVH
`define SOURCE_TEXT_TOKENIZER_UNIT_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication.
`define STT_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("tokenizer check failed");

// Next-cycle implication.
`define STT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("tokenizer check failed");

`else

`define STT_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define STT_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

>>> rtl/stt_pkg.sv
// Shared types, codes and character helpers for the tokenizer.
// No dependencies; used by every RTL module of the block.
package stt_pkg;

    // scan modes
    localparam logic [2:0] MODE_START   = 3'd0;
    localparam logic [2:0] MODE_IDENT   = 3'd1;
    localparam logic [2:0] MODE_NUMBER  = 3'd2;
    localparam logic [2:0] MODE_STROPEN = 3'd3;
    localparam logic [2:0] MODE_STRING  = 3'd4;
    localparam logic [2:0] MODE_COMMENT = 3'd5;
    localparam logic [2:0] MODE_PENDING = 3'd6;

    // token classes
    localparam logic [2:0] CLS_EOL   = 3'd0;
    localparam logic [2:0] CLS_NUM   = 3'd1;
    localparam logic [2:0] CLS_STR   = 3'd2;
    localparam logic [2:0] CLS_SYM   = 3'd3;
    localparam logic [2:0] CLS_IDENT = 3'd4;
    localparam logic [2:0] CLS_ERR   = 3'd5;

    // characters
    localparam logic [7:0] CH_NUL   = 8'd0;
    localparam logic [7:0] CH_NL    = 8'd10;
    localparam logic [7:0] CH_QUOTE = 8'd34;
    localparam logic [7:0] CH_UNDER = 8'd95;
    localparam logic [7:0] CH_DOT   = 8'd46;
    localparam logic [7:0] CH_SLASH = 8'd47;
    localparam logic [7:0] CH_EQ    = 8'd61;
    localparam logic [7:0] CH_LT    = 8'd60;
    localparam logic [7:0] CH_GT    = 8'd62;
    localparam logic [7:0] CH_BANG  = 8'd33;

    // result queue
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    typedef struct packed {
        logic [7:0] token_char;
        logic [2:0] token_class;
        logic       token_first;
        logic       token_last;
        logic       no_char;
        logic       run_end;
    } t_result;

    typedef struct packed {
        logic [1:0] count;
        t_result    res0;
        t_result    res1;
    } t_step_out;

    typedef struct packed {
        logic [2:0] mode;
        logic [7:0] held;
        logic       held_first;
        logic       dot_seen;
    } t_scan_state;

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= 8'd48) && (c <= 8'd57);
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return ((c >= 8'd65) && (c <= 8'd90)) || ((c >= 8'd97) && (c <= 8'd122));
    endfunction

    function automatic logic is_blank(input logic [7:0] c);
        return (c == 8'd32) || (c == 8'd9) || (c == 8'd11) || (c == 8'd12) || (c == 8'd13);
    endfunction

    function automatic logic is_punct(input logic [7:0] c);
        return (c >= 8'd33) && (c <= 8'd126) && !is_digit(c) && !is_alpha(c);
    endfunction

    function automatic logic is_ident(input logic [7:0] c);
        return is_digit(c) || is_alpha(c) || (c == CH_UNDER);
    endfunction

    function automatic logic is_pend(input logic [7:0] c);
        return (c == CH_SLASH) || (c == CH_DOT) || (c == CH_LT) || (c == CH_GT) ||
               (c == CH_BANG) || (c == CH_EQ);
    endfunction

    function automatic logic [7:0] upcase(input logic [7:0] c);
        return ((c >= 8'd97) && (c <= 8'd122)) ? (c - 8'd32) : c;
    endfunction

    function automatic t_result make_res(input logic [7:0] ch, input logic [2:0] cls,
                                         input logic first, input logic last,
                                         input logic nochar);
        t_result r;
        r.token_char  = ch;
        r.token_class = cls;
        r.token_first = first;
        r.token_last  = last;
        r.no_char     = nochar;
        r.run_end     = 1'b0;
        return r;
    endfunction

    function automatic t_result err_res();
        return make_res(CH_NUL, CLS_ERR, 1'b1, 1'b1, 1'b1);
    endfunction

    function automatic t_result eol_res();
        return make_res(CH_NL, CLS_EOL, 1'b1, 1'b1, 1'b0);
    endfunction

endpackage

>>> rtl/stt_step.sv
// Next-state and result logic for one text byte of the tokenizer.
// Depends on stt_pkg.
module stt_step (
    input  logic [7:0]           i_byte,
    input  logic                 i_final,
    input  stt_pkg::t_scan_state i_state,
    output stt_pkg::t_scan_state o_next,
    output stt_pkg::t_step_out   o_out
);

    // what a byte does when it opens a new token
    logic                 sb_valid;
    stt_pkg::t_result     sb_res;
    stt_pkg::t_scan_state sb_state;

    always_comb begin
        sb_valid      = 1'b0;
        sb_res        = stt_pkg::err_res();
        sb_state      = i_state;
        sb_state.mode = stt_pkg::MODE_START;
        if (i_byte == stt_pkg::CH_NL) begin
            sb_valid = 1'b1;
            sb_res   = stt_pkg::eol_res();
        end else if (stt_pkg::is_blank(i_byte)) begin
            sb_valid = 1'b0;
        end else if (stt_pkg::is_alpha(i_byte)) begin
            if (i_final) begin
                sb_valid = 1'b1;
                sb_res   = stt_pkg::make_res(stt_pkg::upcase(i_byte), stt_pkg::CLS_IDENT,
                                             1'b1, 1'b1, 1'b0);
            end else begin
                sb_state.held       = stt_pkg::upcase(i_byte);
                sb_state.held_first = 1'b1;
                sb_state.mode       = stt_pkg::MODE_IDENT;
            end
        end else if (stt_pkg::is_digit(i_byte)) begin
            if (i_final) begin
                sb_valid = 1'b1;
                sb_res   = stt_pkg::make_res(i_byte, stt_pkg::CLS_NUM, 1'b1, 1'b1, 1'b0);
            end else begin
                sb_state.held       = i_byte;
                sb_state.held_first = 1'b1;
                sb_state.mode       = stt_pkg::MODE_NUMBER;
                sb_state.dot_seen   = 1'b0;
            end
        end else if (i_byte == stt_pkg::CH_QUOTE) begin
            if (i_final) begin
                sb_valid = 1'b1;
            end else begin
                sb_state.mode = stt_pkg::MODE_STROPEN;
            end
        end else if (stt_pkg::is_pend(i_byte)) begin
            if (i_final) begin
                sb_valid = 1'b1;
                sb_res   = stt_pkg::make_res(i_byte, stt_pkg::CLS_SYM, 1'b1, 1'b1, 1'b0);
            end else begin
                sb_state.held       = i_byte;
                sb_state.held_first = 1'b1;
                sb_state.mode       = stt_pkg::MODE_PENDING;
            end
        end else if (stt_pkg::is_punct(i_byte)) begin
            sb_valid = 1'b1;
            sb_res   = stt_pkg::make_res(i_byte, stt_pkg::CLS_SYM, 1'b1, 1'b1, 1'b0);
        end else begin
            sb_valid = 1'b1;
        end
    end

    logic [1:0]           cnt;
    stt_pkg::t_result     r0;
    stt_pkg::t_result     r1;
    stt_pkg::t_scan_state nx;
    logic [7:0]           h;
    logic                 hf;

    assign h  = i_state.held;
    assign hf = i_state.held_first;

    always_comb begin
        cnt = 2'd0;
        r0  = stt_pkg::err_res();
        r1  = stt_pkg::err_res();
        nx  = i_state;
        case (i_state.mode)
            stt_pkg::MODE_IDENT: begin
                if (stt_pkg::is_ident(i_byte)) begin
                    r0 = stt_pkg::make_res(h, stt_pkg::CLS_IDENT, hf, 1'b0, 1'b0);
                    if (i_final) begin
                        cnt = 2'd2;
                        r1  = stt_pkg::make_res(stt_pkg::upcase(i_byte), stt_pkg::CLS_IDENT,
                                                1'b0, 1'b1, 1'b0);
                    end else begin
                        cnt           = 2'd1;
                        nx.held       = stt_pkg::upcase(i_byte);
                        nx.held_first = 1'b0;
                    end
                end else begin
                    r0  = stt_pkg::make_res(h, stt_pkg::CLS_IDENT, hf, 1'b1, 1'b0);
                    cnt = 2'd1 + {1'b0, sb_valid};
                    r1  = sb_res;
                    nx  = sb_state;
                end
            end
            stt_pkg::MODE_NUMBER: begin
                if (stt_pkg::is_digit(i_byte) ||
                    ((i_byte == stt_pkg::CH_DOT) && !i_state.dot_seen)) begin
                    if (i_byte == stt_pkg::CH_DOT) begin
                        nx.dot_seen = 1'b1;
                    end
                    r0 = stt_pkg::make_res(h, stt_pkg::CLS_NUM, hf, 1'b0, 1'b0);
                    if (i_final) begin
                        cnt = 2'd2;
                        r1  = stt_pkg::make_res(i_byte, stt_pkg::CLS_NUM, 1'b0, 1'b1, 1'b0);
                    end else begin
                        cnt           = 2'd1;
                        nx.held       = i_byte;
                        nx.held_first = 1'b0;
                    end
                end else begin
                    r0  = stt_pkg::make_res(h, stt_pkg::CLS_NUM, hf, 1'b1, 1'b0);
                    cnt = 2'd1 + {1'b0, sb_valid};
                    r1  = sb_res;
                    nx  = sb_state;
                end
            end
            stt_pkg::MODE_STROPEN: begin
                nx.mode = stt_pkg::MODE_START;
                if (i_byte == stt_pkg::CH_QUOTE) begin
                    cnt = 2'd1;
                    r0  = stt_pkg::make_res(stt_pkg::CH_NUL, stt_pkg::CLS_STR,
                                            1'b1, 1'b1, 1'b1);
                end else if (i_byte == stt_pkg::CH_NL) begin
                    cnt = 2'd2;
                    r1  = stt_pkg::eol_res();
                end else if (i_final) begin
                    cnt = 2'd1;
                end else begin
                    nx.mode       = stt_pkg::MODE_STRING;
                    nx.held       = i_byte;
                    nx.held_first = 1'b1;
                end
            end
            stt_pkg::MODE_STRING: begin
                if (i_byte == stt_pkg::CH_QUOTE) begin
                    cnt     = 2'd1;
                    r0      = stt_pkg::make_res(h, stt_pkg::CLS_STR, hf, 1'b1, 1'b0);
                    nx.mode = stt_pkg::MODE_START;
                end else if (i_byte == stt_pkg::CH_NL) begin
                    // string abandoned: error, then the newline itself
                    cnt     = 2'd2;
                    r1      = stt_pkg::eol_res();
                    nx.mode = stt_pkg::MODE_START;
                end else begin
                    r0 = stt_pkg::make_res(h, stt_pkg::CLS_STR, hf, 1'b0, 1'b0);
                    if (i_final) begin
                        cnt     = 2'd2;
                        nx.mode = stt_pkg::MODE_START;
                    end else begin
                        cnt           = 2'd1;
                        nx.held       = i_byte;
                        nx.held_first = 1'b0;
                    end
                end
            end
            stt_pkg::MODE_COMMENT: begin
                if (i_byte == stt_pkg::CH_NL) begin
                    cnt     = 2'd1;
                    r0      = stt_pkg::eol_res();
                    nx.mode = stt_pkg::MODE_START;
                end
            end
            stt_pkg::MODE_PENDING: begin
                nx.mode = stt_pkg::MODE_START;
                if ((h == stt_pkg::CH_SLASH) && (i_byte == stt_pkg::CH_SLASH)) begin
                    nx.mode = stt_pkg::MODE_COMMENT;
                end else if ((h == stt_pkg::CH_DOT) && stt_pkg::is_digit(i_byte)) begin
                    r0          = stt_pkg::make_res(stt_pkg::CH_DOT, stt_pkg::CLS_NUM,
                                                    1'b1, 1'b0, 1'b0);
                    nx.dot_seen = 1'b1;
                    if (i_final) begin
                        cnt = 2'd2;
                        r1  = stt_pkg::make_res(i_byte, stt_pkg::CLS_NUM, 1'b0, 1'b1, 1'b0);
                    end else begin
                        cnt           = 2'd1;
                        nx.mode       = stt_pkg::MODE_NUMBER;
                        nx.held       = i_byte;
                        nx.held_first = 1'b0;
                    end
                end else if (((h == stt_pkg::CH_LT) || (h == stt_pkg::CH_GT) ||
                              (h == stt_pkg::CH_BANG) || (h == stt_pkg::CH_EQ)) &&
                             (i_byte == stt_pkg::CH_EQ)) begin
                    cnt = 2'd2;
                    r0  = stt_pkg::make_res(h, stt_pkg::CLS_SYM, 1'b1, 1'b0, 1'b0);
                    r1  = stt_pkg::make_res(stt_pkg::CH_EQ, stt_pkg::CLS_SYM,
                                            1'b0, 1'b1, 1'b0);
                end else begin
                    r0  = stt_pkg::make_res(h, stt_pkg::CLS_SYM, 1'b1, 1'b1, 1'b0);
                    cnt = 2'd1 + {1'b0, sb_valid};
                    r1  = sb_res;
                    nx  = sb_state;
                end
            end
            default: begin
                cnt = {1'b0, sb_valid};
                r0  = sb_res;
                nx  = sb_state;
            end
        endcase

        // last byte of the program: everything back to reset
        if (i_final) begin
            nx = '0;
        end

        if (cnt == 2'd1) begin
            r0.run_end = 1'b1;
        end
        if (cnt == 2'd2) begin
            r1.run_end = 1'b1;
        end
    end

    assign o_next      = nx;
    assign o_out.count = cnt;
    assign o_out.res0  = r0;
    assign o_out.res1  = r1;

endmodule

>>> rtl/stt_res_queue.sv
// Small result queue: takes up to two results a cycle, gives one.
// Depends on stt_pkg and the assertion macro header.
`include "source_text_tokenizer_unit_assert.svh"

module stt_res_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push_en,
    input  stt_pkg::t_step_out i_push,
    input  logic               i_pop,
    output logic               o_room,
    output logic               o_valid,
    output stt_pkg::t_result   o_res
);

    stt_pkg::t_result                  r_mem [stt_pkg::QDEPTH];
    logic [stt_pkg::QPTR_W-1:0]        r_wr;
    logic [stt_pkg::QPTR_W-1:0]        r_rd;
    logic [stt_pkg::QCNT_W-1:0]        r_count;
    logic [stt_pkg::QCNT_W-1:0]        n_count;
    logic [1:0]                        push_cnt;
    logic                              pop;

    assign push_cnt = i_push_en ? i_push.count : 2'd0;
    assign pop      = i_pop && (r_count != '0);
    assign n_count  = r_count + stt_pkg::QCNT_W'(push_cnt) - stt_pkg::QCNT_W'(pop);

    always_ff @(posedge i_clk) begin
        if (push_cnt != 2'd0) begin
            r_mem[r_wr] <= i_push.res0;
        end
        if (push_cnt == 2'd2) begin
            r_mem[r_wr + stt_pkg::QPTR_W'(1)] <= i_push.res1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= r_wr + stt_pkg::QPTR_W'(push_cnt);
            r_rd    <= r_rd + stt_pkg::QPTR_W'(pop);
            r_count <= n_count;
        end
    end

    // room for a full two-result push regardless of the output side
    assign o_room  = (r_count <= stt_pkg::QCNT_W'(stt_pkg::QDEPTH - 2));
    assign o_valid = (r_count != '0);
    assign o_res   = r_mem[r_rd];

    `STT_ASSERT_SAME(a_no_overflow, i_clk, i_rst_n, 1'b1, r_count <= stt_pkg::QCNT_W'(stt_pkg::QDEPTH))
    `STT_ASSERT_SAME(a_push_has_room, i_clk, i_rst_n, push_cnt != 2'd0, o_room)
    `STT_ASSERT_NEXT(a_pop_only, i_clk, i_rst_n, pop && (push_cnt == 2'd0), r_count == $past(r_count) - stt_pkg::QCNT_W'(1))

endmodule

>>> rtl/source_text_tokenizer_unit.sv
// Top level of the source text tokenizer: input register, scan logic, result queue.
// Depends on stt_pkg, stt_step, stt_res_queue and the assertion macro header.
`include "source_text_tokenizer_unit_assert.svh"

// Tokenizer for program text. One byte is taken per request on the input channel;
// each byte yields zero, one or two token-character results on the output channel,
// the last one of a byte flagged by o_run_end. A character is held back until the
// next byte shows whether its token goes on, so results trail the bytes that cause
// them; i_final_byte flushes the held character and returns the scanner to its
// reset state. Throughput: one byte per clock as long as bytes average at most one
// result each; the output port delivers one result per clock while i_ready is high,
// so the second result of a byte that gives two (e.g. "<=" or a token end followed
// by a one-byte symbol) waits in a four-entry result queue. A byte passes through
// the input register and then the result queue before its first result reaches the
// output. The input stage stalls only when fewer than two queue entries are free.
module source_text_tokenizer_unit (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // input channel
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_text_byte,
    input  logic       i_final_byte,
    // output channel
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_token_char,
    output logic [2:0] o_token_class,
    output logic       o_token_first,
    output logic       o_token_last,
    output logic       o_no_char,
    output logic       o_run_end
);

    // input register: one byte waiting for the scan logic
    logic                 r_in_valid;
    logic [7:0]           r_in_byte;
    logic                 r_in_final;

    // scanner state
    stt_pkg::t_scan_state r_state;
    stt_pkg::t_scan_state n_state;
    stt_pkg::t_step_out   step_out;

    logic                 q_room;
    logic                 advance;
    stt_pkg::t_result     q_res;

    // the registered byte moves on when the queue can take both possible results
    assign advance = r_in_valid && q_room;
    assign o_ready = !r_in_valid || q_room;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    // payload: no reset needed
    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_in_byte  <= i_text_byte;
            r_in_final <= i_final_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (advance) begin
            r_state <= n_state;
        end
    end

    stt_step u_step (
        .i_byte  (r_in_byte),
        .i_final (r_in_final),
        .i_state (r_state),
        .o_next  (n_state),
        .o_out   (step_out)
    );

    stt_res_queue u_queue (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push_en (advance),
        .i_push    (step_out),
        .i_pop     (i_ready),
        .o_room    (q_room),
        .o_valid   (o_valid),
        .o_res     (q_res)
    );

    assign o_token_char  = q_res.token_char;
    assign o_token_class = q_res.token_class;
    assign o_token_first = q_res.token_first;
    assign o_token_last  = q_res.token_last;
    assign o_no_char     = q_res.no_char;
    assign o_run_end     = q_res.run_end;

    // a final byte always leaves the scanner at token start
    `STT_ASSERT_NEXT(a_final_resets, i_clk, i_rst_n, advance && r_in_final, r_state == '0)
    // a stalled byte keeps its contents and the scanner holds still
    `STT_ASSERT_NEXT(a_stall_holds, i_clk, i_rst_n, r_in_valid && !q_room, r_in_valid && $stable(r_in_byte) && $stable(r_state))
    // the held-back modes are the only ones the scanner can reach besides start/quote/comment
    `STT_ASSERT_SAME(a_mode_range, i_clk, i_rst_n, 1'b1, r_state.mode != 3'd7)

endmodule

>>> dv/tb.sv
// Self-checking testbench for source_text_tokenizer_unit: byte stream in, token characters out.
// Depends on stt_pkg for scan-mode, token-class and character codes; drives the RTL top only.
// Prediction runs on every accepted byte request; results are checked in order as they arrive.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    // one input request: a text byte and its end-of-program flag
    typedef struct packed {
        logic [7:0] text;
        logic       fin;
    } text_t;

    // one token character as the block reports it
    typedef struct packed {
        logic [7:0] ch;
        logic [2:0] cls;
        logic       first;
        logic       last;
        logic       nochar;
        logic       run_end;
    } tok_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       src_valid = 1'b0;
    logic [7:0] src_byte = 8'h00;
    logic       src_final = 1'b0;
    logic       sink_ready = 1'b0;

    logic       o_ready;
    logic       o_valid;
    logic [7:0] o_token_char;
    logic [2:0] o_token_class;
    logic       o_token_first;
    logic       o_token_last;
    logic       o_no_char;
    logic       o_run_end;

    text_t      text_q[$];      // bytes still to be offered
    tok_t       token_q[$];     // token characters predicted, not yet seen
    tok_t       step_toks[$];   // scratch: results of the byte being scanned
    logic [7:0] prog[$];        // scratch: program text being generated

    // scanner shadow state
    logic [2:0] lex_mode = stt_pkg::MODE_START;
    logic [7:0] lex_held = 8'h00;
    logic       lex_held_first = 1'b0;
    logic       lex_dot = 1'b0;

    int         err_count = 0;
    bit         src_taken = 1'b0;
    int         burst_left = 0;
    int         gap_left = 0;
    bit         calm = 1'b0;
    logic [15:0] stall_pat = 16'hFFFF;
    logic [6:0]  stall_step = 7'd0;

    string      sym_pool = "+-*/(),;:<>=!.%&[]{}#$@^|~?'\\_";

    source_text_tokenizer_unit u_dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_valid       (src_valid),
        .o_ready       (o_ready),
        .i_text_byte   (src_byte),
        .i_final_byte  (src_final),
        .o_valid       (o_valid),
        .i_ready       (sink_ready),
        .o_token_char  (o_token_char),
        .o_token_class (o_token_class),
        .o_token_first (o_token_first),
        .o_token_last  (o_token_last),
        .o_no_char     (o_no_char),
        .o_run_end     (o_run_end)
    );

    initial begin
        forever #10 clk = ~clk;
    end

    // ---------------------------------------------------------------
    // Character classes, written out independently of the package functions
    // ---------------------------------------------------------------
    function automatic bit chr_digit(logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic bit chr_letter(logic [7:0] c);
        return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
    endfunction

    function automatic bit chr_blank(logic [7:0] c);
        return c == 8'h20 || (c >= 8'h09 && c <= 8'h0D && c != stt_pkg::CH_NL);
    endfunction

    // printable, not alphanumeric
    function automatic bit chr_punct(logic [7:0] c);
        return c >= 8'h21 && c <= 8'h7E && !chr_digit(c) && !chr_letter(c);
    endfunction

    // bytes that need one byte of lookahead before they can be emitted
    function automatic bit chr_lookahead(logic [7:0] c);
        return c == stt_pkg::CH_SLASH || c == stt_pkg::CH_DOT || c == stt_pkg::CH_LT ||
               c == stt_pkg::CH_GT || c == stt_pkg::CH_BANG || c == stt_pkg::CH_EQ;
    endfunction

    function automatic logic [7:0] to_upper(logic [7:0] c);
        return (c >= "a" && c <= "z") ? c - 8'd32 : c;
    endfunction

    // ---------------------------------------------------------------
    // Token predictor
    // ---------------------------------------------------------------
    function automatic void add_tok(logic [7:0] ch, logic [2:0] cls, logic first,
                                    logic last, logic nochar);
        tok_t t;
        t = '{ch, cls, first, last, nochar, 1'b0};
        if (step_toks.size() < 2) step_toks.insert(step_toks.size(), t);
    endfunction

    function automatic void add_err();
        add_tok(stt_pkg::CH_NUL, stt_pkg::CLS_ERR, 1'b1, 1'b1, 1'b1);
    endfunction

    function automatic void add_eol();
        add_tok(stt_pkg::CH_NL, stt_pkg::CLS_EOL, 1'b1, 1'b1, 1'b0);
    endfunction

    function automatic void hold_char(logic [7:0] c, logic [2:0] mode, logic first);
        lex_held = c;
        lex_held_first = first;
        lex_mode = mode;
    endfunction

    // byte seen with no token open
    function automatic void open_token(logic [7:0] n, bit fin);
        lex_mode = stt_pkg::MODE_START;
        if (n == stt_pkg::CH_NL) begin
            add_eol();
        end else if (chr_blank(n)) begin
        end else if (chr_letter(n)) begin
            if (fin) add_tok(to_upper(n), stt_pkg::CLS_IDENT, 1'b1, 1'b1, 1'b0);
            else hold_char(to_upper(n), stt_pkg::MODE_IDENT, 1'b1);
        end else if (chr_digit(n)) begin
            if (fin) add_tok(n, stt_pkg::CLS_NUM, 1'b1, 1'b1, 1'b0);
            else begin
                hold_char(n, stt_pkg::MODE_NUMBER, 1'b1);
                lex_dot = 1'b0;
            end
        end else if (n == stt_pkg::CH_QUOTE) begin
            if (fin) add_err();
            else lex_mode = stt_pkg::MODE_STROPEN;
        end else if (chr_lookahead(n)) begin
            if (fin) add_tok(n, stt_pkg::CLS_SYM, 1'b1, 1'b1, 1'b0);
            else hold_char(n, stt_pkg::MODE_PENDING, 1'b1);
        end else if (chr_punct(n)) begin
            add_tok(n, stt_pkg::CLS_SYM, 1'b1, 1'b1, 1'b0);
        end else begin
            add_err();
        end
    endfunction

    // scan one accepted byte and queue the token characters it releases
    function automatic void scan_byte(logic [7:0] n, bit fin);
        logic [7:0] h;
        h = lex_held;
        step_toks.delete();
        case (lex_mode)
            stt_pkg::MODE_IDENT: begin
                if (chr_digit(n) || chr_letter(n) || n == stt_pkg::CH_UNDER) begin
                    add_tok(h, stt_pkg::CLS_IDENT, lex_held_first, 1'b0, 1'b0);
                    if (fin) add_tok(to_upper(n), stt_pkg::CLS_IDENT, 1'b0, 1'b1, 1'b0);
                    else hold_char(to_upper(n), stt_pkg::MODE_IDENT, 1'b0);
                end else begin
                    add_tok(h, stt_pkg::CLS_IDENT, lex_held_first, 1'b1, 1'b0);
                    open_token(n, fin);
                end
            end
            stt_pkg::MODE_NUMBER: begin
                if (chr_digit(n) || (n == stt_pkg::CH_DOT && !lex_dot)) begin
                    if (n == stt_pkg::CH_DOT) lex_dot = 1'b1;
                    add_tok(h, stt_pkg::CLS_NUM, lex_held_first, 1'b0, 1'b0);
                    if (fin) add_tok(n, stt_pkg::CLS_NUM, 1'b0, 1'b1, 1'b0);
                    else hold_char(n, stt_pkg::MODE_NUMBER, 1'b0);
                end else begin
                    add_tok(h, stt_pkg::CLS_NUM, lex_held_first, 1'b1, 1'b0);
                    open_token(n, fin);
                end
            end
            stt_pkg::MODE_STROPEN: begin
                lex_mode = stt_pkg::MODE_START;
                if (n == stt_pkg::CH_QUOTE) begin
                    add_tok(stt_pkg::CH_NUL, stt_pkg::CLS_STR, 1'b1, 1'b1, 1'b1);
                end else if (n == stt_pkg::CH_NL) begin
                    add_err();
                    add_eol();
                end else if (fin) add_err();
                else hold_char(n, stt_pkg::MODE_STRING, 1'b1);
            end
            stt_pkg::MODE_STRING: begin
                if (n == stt_pkg::CH_QUOTE) begin
                    add_tok(h, stt_pkg::CLS_STR, lex_held_first, 1'b1, 1'b0);
                    lex_mode = stt_pkg::MODE_START;
                end else if (n == stt_pkg::CH_NL) begin
                    // string abandoned: error replaces the pending char
                    add_err();
                    add_eol();
                    lex_mode = stt_pkg::MODE_START;
                end else begin
                    add_tok(h, stt_pkg::CLS_STR, lex_held_first, 1'b0, 1'b0);
                    if (fin) begin
                        add_err();
                        lex_mode = stt_pkg::MODE_START;
                    end else hold_char(n, stt_pkg::MODE_STRING, 1'b0);
                end
            end
            stt_pkg::MODE_COMMENT: begin
                if (n == stt_pkg::CH_NL) begin
                    add_eol();
                    lex_mode = stt_pkg::MODE_START;
                end
            end
            stt_pkg::MODE_PENDING: begin
                lex_mode = stt_pkg::MODE_START;
                if (h == stt_pkg::CH_SLASH && n == stt_pkg::CH_SLASH) begin
                    lex_mode = stt_pkg::MODE_COMMENT;
                end else if (h == stt_pkg::CH_DOT && chr_digit(n)) begin
                    add_tok(stt_pkg::CH_DOT, stt_pkg::CLS_NUM, 1'b1, 1'b0, 1'b0);
                    lex_dot = 1'b1;
                    if (fin) add_tok(n, stt_pkg::CLS_NUM, 1'b0, 1'b1, 1'b0);
                    else hold_char(n, stt_pkg::MODE_NUMBER, 1'b0);
                end else if ((h == stt_pkg::CH_LT || h == stt_pkg::CH_GT ||
                              h == stt_pkg::CH_BANG || h == stt_pkg::CH_EQ) &&
                             n == stt_pkg::CH_EQ) begin
                    add_tok(h, stt_pkg::CLS_SYM, 1'b1, 1'b0, 1'b0);
                    add_tok(stt_pkg::CH_EQ, stt_pkg::CLS_SYM, 1'b0, 1'b1, 1'b0);
                end else begin
                    add_tok(h, stt_pkg::CLS_SYM, 1'b1, 1'b1, 1'b0);
                    open_token(n, fin);
                end
            end
            default: open_token(n, fin);
        endcase
        // end of program: everything back to reset values
        if (fin) begin
            lex_mode = stt_pkg::MODE_START;
            lex_held = 8'h00;
            lex_held_first = 1'b0;
            lex_dot = 1'b0;
        end
        if (step_toks.size() > 0) step_toks[step_toks.size() - 1].run_end = 1'b1;
        foreach (step_toks[i]) token_q.insert(token_q.size(), step_toks[i]);
    endfunction

    // ---------------------------------------------------------------
    // Stimulus generation
    // ---------------------------------------------------------------
    function automatic void add_text(logic [7:0] c, bit fin);
        text_t t;
        t = '{c, fin};
        text_q.insert(text_q.size(), t);
    endfunction

    function automatic void push_text(string s, bit fin_last);
        for (int i = 0; i < s.len(); i++)
            add_text(s[i], fin_last && (i == s.len() - 1));
    endfunction

    // append one byte to the program being generated
    function automatic void prog_add(logic [7:0] c);
        prog.insert(prog.size(), c);
    endfunction

    function automatic logic [7:0] rnd_letter();
        int r;
        r = $urandom_range(0, 51);
        return (r < 26) ? 8'(65 + r) : 8'(71 + r);
    endfunction

    function automatic logic [7:0] rnd_digit();
        return 8'(48 + $urandom_range(0, 9));
    endfunction

    // append one random token (mostly well formed) plus an optional blank
    function automatic void gen_token();
        int kind;
        int n;
        logic [7:0] c;
        kind = $urandom_range(0, 99);
        if (kind < 25) begin
            prog_add(rnd_letter());
            repeat ($urandom_range(0, 5)) begin
                case ($urandom_range(0, 3))
                    0: prog_add(rnd_digit());
                    1: prog_add(stt_pkg::CH_UNDER);
                    default: prog_add(rnd_letter());
                endcase
            end
        end else if (kind < 45) begin
            if ($urandom_range(0, 7) == 0) prog_add(stt_pkg::CH_DOT);
            repeat ($urandom_range(1, 4)) prog_add(rnd_digit());
            if ($urandom_range(0, 2) == 0) begin
                prog_add(stt_pkg::CH_DOT);
                repeat ($urandom_range(0, 3)) prog_add(rnd_digit());
                // second dot ends the number
                if ($urandom_range(0, 5) == 0) prog_add(stt_pkg::CH_DOT);
            end
        end else if (kind < 60) begin
            prog_add(stt_pkg::CH_QUOTE);
            repeat ($urandom_range(0, 5)) begin
                do c = 8'($urandom_range(0, 255));
                while (c == stt_pkg::CH_QUOTE || c == stt_pkg::CH_NL);
                prog_add(c);
            end
            case ($urandom_range(0, 19))
                0: prog_add(stt_pkg::CH_NL);
                1: ;  // left open
                default: prog_add(stt_pkg::CH_QUOTE);
            endcase
        end else if (kind < 72) begin
            n = $urandom_range(0, 9);
            if (n < 4) begin
                prog_add(n == 0 ? stt_pkg::CH_LT : n == 1 ? stt_pkg::CH_GT :
                         n == 2 ? stt_pkg::CH_BANG : stt_pkg::CH_EQ);
                prog_add(stt_pkg::CH_EQ);
            end else begin
                prog_add(sym_pool[$urandom_range(0, sym_pool.len() - 1)]);
            end
        end else if (kind < 78) begin
            prog_add(stt_pkg::CH_SLASH);
            prog_add(stt_pkg::CH_SLASH);
            repeat ($urandom_range(0, 6)) prog_add(8'($urandom_range(32, 126)));
            prog_add(stt_pkg::CH_NL);
        end else if (kind < 86) begin
            prog_add(stt_pkg::CH_NL);
        end else if (kind < 94) begin
            case ($urandom_range(0, 4))
                0: prog_add(8'h09);
                1: prog_add(8'h0B);
                2: prog_add(8'h0C);
                3: prog_add(8'h0D);
                default: prog_add(8'h20);
            endcase
        end else begin
            prog_add(8'($urandom_range(0, 255)));
        end
        if ($urandom_range(0, 1) == 0) prog_add(8'h20);
    endfunction

    // ---------------------------------------------------------------
    // Byte request driver: bursts with random gaps, calm stretches
    // ---------------------------------------------------------------
    always @(negedge clk) begin
        text_t nxt;
        if (rst_n && (!src_valid || src_taken)) begin
            src_taken = 1'b0;
            if (gap_left > 0) begin
                gap_left--;
                src_valid <= 1'b0;
            end else if (text_q.size() == 0) begin
                src_valid <= 1'b0;
            end else begin
                nxt = text_q.pop_front();
                src_byte  <= nxt.text;
                src_final <= nxt.fin;
                src_valid <= 1'b1;
                if (burst_left > 0) begin
                    burst_left--;
                end else begin
                    burst_left = $urandom_range(0, 23);
                    if ($urandom_range(0, 7) == 0) calm = !calm;
                    gap_left = calm ? 0 : $urandom_range(1, 6);
                end
            end
        end
    end

    // Result sink: ready follows a 16-bit pattern, reshuffled whenever stall_step wraps
    always @(negedge clk) begin
        if (stall_step == 7'd0) begin
            case ($urandom_range(0, 7))
                0, 1: stall_pat = 16'hFFFF;
                2: stall_pat = 16'h0001 << $urandom_range(0, 15);
                default: stall_pat = 16'($urandom) | 16'h0001;
            endcase
        end
        sink_ready <= stall_pat[stall_step[3:0]];
        stall_step = stall_step + 7'd1;
    end

    // ---------------------------------------------------------------
    // Monitor: predict on every accepted byte request, check every result request
    // ---------------------------------------------------------------
    always @(posedge clk) begin
        tok_t got;
        tok_t want;
        if (rst_n) begin
            if (src_valid && o_ready) begin
                scan_byte(src_byte, src_final);
                src_taken = 1'b1;
            end
            if (o_valid && sink_ready) begin
                got = '{o_token_char, o_token_class, o_token_first, o_token_last,
                        o_no_char, o_run_end};
                if (token_q.size() == 0) begin
                    if (err_count < 10)
                        $display({"%0t: unexpected result char=%02h class=%0d first=%0b",
                                  " last=%0b nochar=%0b end=%0b"},
                                 $time, got.ch, got.cls, got.first, got.last, got.nochar,
                                 got.run_end);
                    err_count++;
                end else begin
                    want = token_q.pop_front();
                    if (got.ch !== want.ch || got.cls !== want.cls ||
                        got.first !== want.first || got.last !== want.last ||
                        got.nochar !== want.nochar || got.run_end !== want.run_end) begin
                        if (err_count < 10) begin
                            $write({"%0t: mismatch expected char=%02h class=%0d first=%0b",
                                    " last=%0b nochar=%0b end=%0b,"},
                                   $time, want.ch, want.cls, want.first, want.last,
                                   want.nochar, want.run_end);
                            $display(" got char=%02h class=%0d first=%0b last=%0b nochar=%0b end=%0b",
                                     got.ch, got.cls, got.first, got.last, got.nochar,
                                     got.run_end);
                        end
                        err_count++;
                    end
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // Sequence: directed text, random programs, drain, verdict
    // ---------------------------------------------------------------
    initial begin
        int len;
        // number run with leading dot and second dot, <=, empty string on final byte
        push_text("z_9<=.5.\"\"", 1'b1);
        // newline inside a string, lone slash, comment closed by a final newline
        push_text("\"a\n/ //c\n", 1'b1);
        // unknown bytes, then a quote as the final byte
        add_text(8'h00, 1'b0);
        add_text(8'hFF, 1'b0);
        add_text(8'h7F, 1'b0);
        add_text(stt_pkg::CH_QUOTE, 1'b1);
        // string left open at the final byte
        push_text("\"xy", 1'b1);

        while (text_q.size() < 1530) begin
            prog.delete();
            len = $urandom_range(3, 50);
            while (prog.size() < len) gen_token();
            // occasional early final byte cuts a program short
            foreach (prog[i])
                add_text(prog[i], (i == prog.size() - 1) || ($urandom_range(0, 39) == 0));
        end

        repeat (5) @(posedge clk);
        @(negedge clk) rst_n <= 1'b1;

        while (text_q.size() != 0 || src_valid) @(negedge clk);
        while (token_q.size() != 0) @(negedge clk);
        repeat (16) @(negedge clk);

        if (token_q.size() != 0) begin
            $display("%0d expected results never arrived", token_q.size());
            err_count++;
        end
        if (err_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // hang guard: far beyond the slowest legal run
    initial begin
        #(10_000_000);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

>>> filelist.f
+incdir+rtl
rtl/stt_pkg.sv
rtl/stt_step.sv
rtl/stt_res_queue.sv
rtl/source_text_tokenizer_unit.sv
dv/tb.sv
